// ----- rtl/xml_fragment_tokenizer_assert.svh -----
// assertion macros shared by the tokenizer rtl
`ifndef XML_FRAGMENT_TOKENIZER_ASSERT_SVH
`define XML_FRAGMENT_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define XFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define XFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/xft_pkg.sv -----
`timescale 1ns / 1ps

package xft_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] kind_t;
  typedef logic [1:0] err_t;

  // fragment kinds
  localparam kind_t KindText    = 3'd0;
  localparam kind_t KindCdata   = 3'd1;
  localparam kind_t KindStart   = 3'd2;
  localparam kind_t KindEmpty   = 3'd3;
  localparam kind_t KindEndTag  = 3'd4;
  localparam kind_t KindComment = 3'd5;
  localparam kind_t KindXmlDecl = 3'd6;
  localparam kind_t KindPending = 3'd7;

  // error codes
  localparam err_t ErrNone    = 2'd0;
  localparam err_t ErrUnknown = 2'd1;
  localparam err_t ErrEnd     = 2'd2;
  localparam err_t ErrDepth   = 2'd3;

  // characters
  localparam byte_t ChNul      = 8'h00;
  localparam byte_t ChLt       = 8'h3C;
  localparam byte_t ChGt       = 8'h3E;
  localparam byte_t ChSlash    = 8'h2F;
  localparam byte_t ChBang     = 8'h21;
  localparam byte_t ChQuest    = 8'h3F;
  localparam byte_t ChDash     = 8'h2D;
  localparam byte_t ChRBracket = 8'h5D;
  localparam byte_t ChDquote   = 8'h22;
  localparam byte_t ChSquote   = 8'h27;

  // "[CDATA[" by position
  function automatic byte_t cdata_char(input logic [2:0] pos);
    byte_t c;
    case (pos)
      3'd0: c = 8'h5B;
      3'd1: c = 8'h43;
      3'd2: c = 8'h44;
      3'd3: c = 8'h41;
      3'd4: c = 8'h54;
      3'd5: c = 8'h41;
      default: c = 8'h5B;
    endcase
    return c;
  endfunction

  // "DOCTYPE" by position
  function automatic byte_t doctype_char(input logic [2:0] pos);
    byte_t c;
    case (pos)
      3'd0: c = 8'h44;
      3'd1: c = 8'h4F;
      3'd2: c = 8'h43;
      3'd3: c = 8'h54;
      3'd4: c = 8'h59;
      3'd5: c = 8'h50;
      default: c = 8'h45;
    endcase
    return c;
  endfunction

  // "xml" by position
  function automatic byte_t xml_char(input logic [1:0] pos);
    byte_t c;
    case (pos)
      2'd0: c = 8'h78;
      2'd1: c = 8'h6D;
      default: c = 8'h6C;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/xft_if.sv -----
`timescale 1ns / 1ps

interface xft_byte_if;
  import xft_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface xft_tok_if;
  import xft_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte_echo;
  kind_t frag_kind;
  logic  frag_start;
  logic  frag_end;
  logic  doctype_flag;
  byte_t nest_depth;
  logic  doc_done;
  err_t  error_code;

  modport source (
    output valid, output byte_echo, output frag_kind, output frag_start,
    output frag_end, output doctype_flag, output nest_depth, output doc_done,
    output error_code, input ready
  );
  modport sink (
    input valid, input byte_echo, input frag_kind, input frag_start,
    input frag_end, input doctype_flag, input nest_depth, input doc_done,
    input error_code, output ready
  );
endinterface

// ----- rtl/xml_fragment_tokenizer.sv -----
// a transferred byte goes into the input register, then through the scanner
// logic into the result register
// throughput: one byte per cycle while the result side does not stall; the scanner state updates once per byte
// a stalled result holds the pipe; the input register still fills behind it
// reset (rst_ni low, asynchronous) empties both registers and returns the
// scanner to between fragments, depth zero, no error
`timescale 1ns / 1ps

`include "xml_fragment_tokenizer_assert.svh"

module xml_fragment_tokenizer #(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  xft_byte_if.sink       byte_in_i,
  xft_tok_if.source      tok_out_o
);
  import xft_pkg::*;

  localparam int unsigned DepthLimitInt = (MAX_DEPTH > 255) ? 255 : MAX_DEPTH;
  localparam byte_t       DepthLimit    = DepthLimitInt[7:0];

  localparam logic [1:0] QuoteNone   = 2'd0;
  localparam logic [1:0] QuoteDouble = 2'd1;
  localparam logic [1:0] QuoteSingle = 2'd2;

  typedef enum logic [3:0] {
    ModeIdle, ModeText, ModeLt, ModeBang, ModeBangDash, ModeCdataMatch,
    ModeDoctypeMatch, ModeQMatch, ModeStart, ModeEnd, ModeXmlDecl,
    ModeComment, ModeCdata, ModeDoctype, ModeDone
  } mode_e;

  // pipeline control
  logic  in_valid_q;
  byte_t in_byte_q;
  logic  out_valid_q;
  logic  out_en;
  logic  advance;

  // scanner state
  mode_e      mode_q, mode_d;
  logic [2:0] la_q, la_d;
  logic [1:0] run_q, run_d;
  logic [1:0] quote_q, quote_d;
  logic       slash_q, slash_d;
  byte_t      depth_q, depth_d;
  err_t       err_q, err_d;

  // result of the current byte
  kind_t kind;
  logic  fstart, fend, dt, done;
  err_t  err;
  logic  tag;
  logic [2:0] mpos;
  logic [1:0] qpos;
  byte_t pat;
  byte_t b;

  // result register
  byte_t echo_q;
  kind_t kind_q;
  logic  fstart_q, fend_q, dt_q, done_q;
  byte_t depth_out_q;
  err_t  err_out_q;

  assign out_en  = !out_valid_q || tok_out_o.ready;
  assign advance = in_valid_q && out_en;
  assign byte_in_i.ready = !in_valid_q || out_en;
  assign b = in_byte_q;

  always_comb begin
    mode_d  = mode_q;
    la_d    = la_q;
    run_d   = run_q;
    quote_d = quote_q;
    slash_d = slash_q;
    depth_d = depth_q;
    err_d   = err_q;
    kind    = KindText;
    fstart  = 1'b0;
    fend    = 1'b0;
    dt      = 1'b0;
    done    = 1'b0;
    err     = ErrNone;
    tag     = 1'b0;
    mpos    = (la_q == 3'd7) ? 3'd6 : la_q;
    qpos    = (la_q >= 3'd3) ? 2'd2 : la_q[1:0];
    pat     = (mode_q == ModeCdataMatch) ? cdata_char(mpos) : doctype_char(mpos);

    if (err_q != ErrNone) begin
      // latched error: hold everything
    end else if (mode_q == ModeDone) begin
      done = 1'b1;
    end else begin
      case (mode_q)
        ModeIdle, ModeText: begin
          if (b == ChNul) begin
            mode_d = ModeDone;
            done   = 1'b1;
          end else if (b == ChLt) begin
            mode_d = ModeLt;
            kind   = KindPending;
            fstart = 1'b1;
          end else begin
            kind   = KindText;
            fstart = (mode_q == ModeIdle);
            mode_d = ModeText;
          end
        end
        ModeLt: begin
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b == ChSlash) begin
            mode_d  = ModeEnd;
            kind    = KindEndTag;
            quote_d = QuoteNone;
          end else if (b == ChBang) begin
            mode_d = ModeBang;
            kind   = KindPending;
          end else if (b == ChQuest) begin
            mode_d = ModeQMatch;
            la_d   = 3'd0;
            kind   = KindPending;
          end else begin
            mode_d  = ModeStart;
            quote_d = QuoteNone;
            slash_d = 1'b0;
            tag     = 1'b1;
          end
        end
        ModeBang: begin
          kind = KindPending;
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b == ChDash) begin
            mode_d = ModeBangDash;
          end else if (b == cdata_char(3'd0)) begin
            mode_d = ModeCdataMatch;
            la_d   = 3'd1;
          end else if (b == doctype_char(3'd0)) begin
            mode_d = ModeDoctypeMatch;
            la_d   = 3'd1;
          end else begin
            err = ErrUnknown;
          end
        end
        ModeBangDash: begin
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b == ChDash) begin
            mode_d = ModeComment;
            run_d  = 2'd0;
            kind   = KindComment;
          end else begin
            err = ErrUnknown;
          end
        end
        ModeCdataMatch, ModeDoctypeMatch: begin
          kind = KindPending;
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b != pat) begin
            err = ErrUnknown;
          end else if (mpos == 3'd6) begin
            la_d  = 3'd0;
            run_d = 2'd0;
            if (mode_q == ModeCdataMatch) begin
              mode_d = ModeCdata;
              kind   = KindCdata;
            end else begin
              mode_d = ModeDoctype;
            end
          end else begin
            la_d = mpos + 3'd1;
          end
        end
        ModeQMatch: begin
          kind = KindPending;
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b != xml_char(qpos)) begin
            err = ErrUnknown;
          end else if (qpos == 2'd2) begin
            la_d    = 3'd0;
            mode_d  = ModeXmlDecl;
            quote_d = QuoteNone;
            slash_d = 1'b0;
            kind    = KindXmlDecl;
          end else begin
            la_d = {1'b0, qpos} + 3'd1;
          end
        end
        ModeStart, ModeEnd, ModeXmlDecl: begin
          tag = 1'b1;
        end
        ModeComment: begin
          kind = KindComment;
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b == ChDash) begin
            if (run_q != 2'd3) run_d = run_q + 2'd1;
          end else if (b == ChGt && run_q == 2'd2) begin
            fend   = 1'b1;
            mode_d = ModeIdle;
            run_d  = 2'd0;
          end else begin
            run_d = 2'd0;
          end
        end
        ModeCdata: begin
          kind = KindCdata;
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b == ChRBracket) begin
            if (run_q < 2'd2) run_d = run_q + 2'd1;
          end else if (b == ChGt && run_q >= 2'd2) begin
            fend   = 1'b1;
            mode_d = ModeIdle;
            run_d  = 2'd0;
          end else begin
            run_d = 2'd0;
          end
        end
        ModeDoctype: begin
          kind = KindPending;
          if (b == ChNul) begin
            err = ErrEnd;
          end else if (b == ChGt) begin
            fend   = 1'b1;
            dt     = 1'b1;
            mode_d = ModeIdle;
          end
        end
        default: begin
          mode_d = ModeIdle;
        end
      endcase

      // tag and declaration bodies, with quoted values
      if (tag && err == ErrNone) begin
        kind = (mode_d == ModeStart) ? KindStart :
               (mode_d == ModeEnd) ? KindEndTag : KindXmlDecl;
        if (b == ChNul) begin
          err = ErrEnd;
        end else if (quote_d == QuoteDouble || quote_d == QuoteSingle) begin
          if ((quote_d == QuoteDouble && b == ChDquote) ||
              (quote_d == QuoteSingle && b == ChSquote)) begin
            quote_d = QuoteNone;
          end
          slash_d = 1'b0;
        end else if (b == ChDquote) begin
          quote_d = QuoteDouble;
          slash_d = 1'b0;
        end else if (b == ChSquote) begin
          quote_d = QuoteSingle;
          slash_d = 1'b0;
        end else if (b == ChGt) begin
          if (mode_d == ModeStart) begin
            if (slash_d) begin
              kind = KindEmpty;
            end else if (depth_q >= DepthLimit) begin
              err = ErrDepth;
            end else begin
              depth_d = depth_q + 8'd1;
            end
          end else if (mode_d == ModeEnd) begin
            if (depth_q == 8'd0) begin
              err = ErrDepth;
            end else begin
              depth_d = depth_q - 8'd1;
            end
          end
          if (err == ErrNone) begin
            fend    = 1'b1;
            mode_d  = ModeIdle;
            quote_d = QuoteNone;
            slash_d = 1'b0;
          end
        end else begin
          slash_d = (b == ChSlash);
        end
      end

      if (err != ErrNone) err_d = err;
    end

    if (err_d != ErrNone) begin
      kind   = KindText;
      fstart = 1'b0;
      fend   = 1'b0;
      dt     = 1'b0;
      done   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_byte_q   <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeIdle;
      la_q        <= '0;
      run_q       <= '0;
      quote_q     <= QuoteNone;
      slash_q     <= 1'b0;
      depth_q     <= '0;
      err_q       <= ErrNone;
      echo_q      <= '0;
      kind_q      <= KindText;
      fstart_q    <= 1'b0;
      fend_q      <= 1'b0;
      dt_q        <= 1'b0;
      done_q      <= 1'b0;
      depth_out_q <= '0;
      err_out_q   <= ErrNone;
    end else begin
      if (byte_in_i.ready) begin
        in_valid_q <= byte_in_i.valid;
        if (byte_in_i.valid) in_byte_q <= byte_in_i.data_byte;
      end
      if (out_en) out_valid_q <= in_valid_q;
      if (advance) begin
        mode_q      <= mode_d;
        la_q        <= la_d;
        run_q       <= run_d;
        quote_q     <= quote_d;
        slash_q     <= slash_d;
        depth_q     <= depth_d;
        err_q       <= err_d;
        echo_q      <= b;
        kind_q      <= kind;
        fstart_q    <= fstart;
        fend_q      <= fend;
        dt_q        <= dt;
        done_q      <= done;
        depth_out_q <= depth_d;
        err_out_q   <= err_d;
      end
    end
  end

  assign tok_out_o.valid        = out_valid_q;
  assign tok_out_o.byte_echo    = echo_q;
  assign tok_out_o.frag_kind    = kind_q;
  assign tok_out_o.frag_start   = fstart_q;
  assign tok_out_o.frag_end     = fend_q;
  assign tok_out_o.doctype_flag = dt_q;
  assign tok_out_o.nest_depth   = depth_out_q;
  assign tok_out_o.doc_done     = done_q;
  assign tok_out_o.error_code   = err_out_q;

  // an error never clears or changes once latched
  `XFT_ASSERT_NEXT(a_err_sticky, err_q != ErrNone, err_q == $past(err_q),
                   "latched error changed")
  // depth moves by at most one per byte
  `XFT_ASSERT_NEXT(a_depth_step, 1'b1,
                   depth_q == $past(depth_q) || depth_q == $past(depth_q) + 8'd1 ||
                   depth_q == $past(depth_q) - 8'd1,
                   "depth jumped by more than one")
  `XFT_ASSERT_NOW(a_depth_limit, 1'b1, depth_q <= DepthLimit,
                  "depth above limit")
  // an error result carries no fragment information
  `XFT_ASSERT_NOW(a_err_quiet, out_valid_q && err_out_q != ErrNone,
                  kind_q == KindText && !fstart_q && !fend_q && !dt_q && !done_q,
                  "error result with fragment flags")
  // input side stalls only behind a stalled full result register
  `XFT_ASSERT_NOW(a_stall_cause, !byte_in_i.ready,
                  in_valid_q && out_valid_q && !tok_out_o.ready,
                  "input stalled without output back-pressure")

endmodule

// ----- verif/xft_tokenizer_checker.sv -----
`timescale 1ns / 1ps

module xft_tokenizer_checker
  import xft_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  xft_byte_if  byte_mon,
  xft_tok_if   tok_mon,
  output int   fail_o,
  output int   pending_o
);

  typedef enum logic [3:0] {
    ScIdle, ScText, ScLt, ScBang, ScBangDash, ScCdataMatch, ScDoctypeMatch,
    ScQMatch, ScStart, ScEnd, ScDecl, ScComment, ScCdata, ScDoctype, ScDone
  } scan_e;

  typedef struct packed {
    byte_t byte_echo;
    kind_t frag_kind;
    logic  frag_start;
    logic  frag_end;
    logic  doctype_flag;
    byte_t nest_depth;
    logic  doc_done;
    err_t  error_code;
  } tok_t;

  localparam logic [1:0] QuoteNone   = 2'd0;
  localparam logic [1:0] QuoteDouble = 2'd1;
  localparam logic [1:0] QuoteSingle = 2'd2;

  localparam logic [55:0] CdataWord   = "[CDATA[";
  localparam logic [55:0] DoctypeWord = "DOCTYPE";
  localparam logic [23:0] XmlWord     = "xml";

  localparam int unsigned DepthCap = (MAX_DEPTH > 255) ? 255 : MAX_DEPTH;

  scan_e      scan_q;
  logic [3:0] match_pos;
  logic [1:0] run_q;
  logic [1:0] quote_q;
  logic       slash_q;
  byte_t      depth_q;
  err_t       err_q;

  tok_t tok_exp_q[$];
  int   fail_n;

  assign fail_o    = fail_n;
  assign pending_o = tok_exp_q.size();

  // advances the scanner by one byte and returns the token it should report
  function automatic tok_t tokenize_byte(input byte_t b);
    tok_t       t;
    logic       tag;
    err_t       err;
    logic [2:0] pos;
    byte_t      want_ch;
    t = '0;
    t.byte_echo = b;
    tag = 1'b0;
    err = ErrNone;
    if (err_q != ErrNone) begin
      // latched: state frozen
    end else if (scan_q == ScDone) begin
      t.doc_done = 1'b1;
    end else begin
      case (scan_q)
        ScIdle, ScText: begin
          if (b == ChNul) begin
            scan_q = ScDone;
            t.doc_done = 1'b1;
          end else if (b == ChLt) begin
            scan_q = ScLt;
            t.frag_kind = KindPending;
            t.frag_start = 1'b1;
          end else begin
            t.frag_kind = KindText;
            t.frag_start = (scan_q == ScIdle);
            scan_q = ScText;
          end
        end
        ScLt: begin
          if (b == ChNul) err = ErrEnd;
          else if (b == ChSlash) begin
            scan_q = ScEnd;
            t.frag_kind = KindEndTag;
            quote_q = QuoteNone;
          end else if (b == ChBang) begin
            scan_q = ScBang;
            t.frag_kind = KindPending;
          end else if (b == ChQuest) begin
            scan_q = ScQMatch;
            match_pos = '0;
            t.frag_kind = KindPending;
          end else begin
            // any other byte already belongs to the start tag body
            scan_q = ScStart;
            quote_q = QuoteNone;
            slash_q = 1'b0;
            tag = 1'b1;
          end
        end
        ScBang: begin
          t.frag_kind = KindPending;
          if (b == ChNul) err = ErrEnd;
          else if (b == ChDash) scan_q = ScBangDash;
          else if (b == CdataWord[55 -: 8]) begin
            scan_q = ScCdataMatch;
            match_pos = 4'd1;
          end else if (b == DoctypeWord[55 -: 8]) begin
            scan_q = ScDoctypeMatch;
            match_pos = 4'd1;
          end else err = ErrUnknown;
        end
        ScBangDash: begin
          if (b == ChNul) err = ErrEnd;
          else if (b == ChDash) begin
            scan_q = ScComment;
            run_q = '0;
            t.frag_kind = KindComment;
          end else err = ErrUnknown;
        end
        ScCdataMatch, ScDoctypeMatch: begin
          pos = (match_pos < 4'd7) ? match_pos[2:0] : 3'd6;
          want_ch = (scan_q == ScCdataMatch) ? CdataWord[8*(6-pos) +: 8]
                                             : DoctypeWord[8*(6-pos) +: 8];
          t.frag_kind = KindPending;
          if (b == ChNul) err = ErrEnd;
          else if (b != want_ch) err = ErrUnknown;
          else begin
            match_pos = pos + 4'd1;
            if (match_pos >= 4'd7) begin
              match_pos = '0;
              run_q = '0;
              if (scan_q == ScCdataMatch) begin
                scan_q = ScCdata;
                t.frag_kind = KindCdata;
              end else scan_q = ScDoctype;
            end
          end
        end
        ScQMatch: begin
          pos = (match_pos < 4'd3) ? match_pos[2:0] : 3'd2;
          want_ch = XmlWord[8*(2-pos) +: 8];
          t.frag_kind = KindPending;
          if (b == ChNul) err = ErrEnd;
          else if (b != want_ch) err = ErrUnknown;
          else begin
            match_pos = pos + 4'd1;
            if (match_pos >= 4'd3) begin
              match_pos = '0;
              scan_q = ScDecl;
              quote_q = QuoteNone;
              slash_q = 1'b0;
              t.frag_kind = KindXmlDecl;
            end
          end
        end
        ScStart, ScEnd, ScDecl: tag = 1'b1;
        ScComment: begin
          t.frag_kind = KindComment;
          if (b == ChNul) err = ErrEnd;
          else if (b == ChDash) begin
            if (run_q < 2'd3) run_q++;
          end else if (b == ChGt && run_q == 2'd2) begin
            t.frag_end = 1'b1;
            scan_q = ScIdle;
            run_q = '0;
          end else run_q = '0;
        end
        ScCdata: begin
          t.frag_kind = KindCdata;
          if (b == ChNul) err = ErrEnd;
          else if (b == ChRBracket) begin
            if (run_q < 2'd2) run_q++;
          end else if (b == ChGt && run_q >= 2'd2) begin
            t.frag_end = 1'b1;
            scan_q = ScIdle;
            run_q = '0;
          end else run_q = '0;
        end
        ScDoctype: begin
          t.frag_kind = KindPending;
          if (b == ChNul) err = ErrEnd;
          else if (b == ChGt) begin
            t.frag_end = 1'b1;
            t.doctype_flag = 1'b1;
            scan_q = ScIdle;
          end
        end
        default: scan_q = ScIdle;
      endcase

      // tag and declaration bodies: quotes hide '>' and '/'
      if (tag && err == ErrNone) begin
        t.frag_kind = (scan_q == ScStart) ? KindStart :
                      (scan_q == ScEnd)   ? KindEndTag : KindXmlDecl;
        if (b == ChNul) err = ErrEnd;
        else if (quote_q == QuoteDouble || quote_q == QuoteSingle) begin
          if ((quote_q == QuoteDouble && b == ChDquote) ||
              (quote_q == QuoteSingle && b == ChSquote)) quote_q = QuoteNone;
          slash_q = 1'b0;
        end else if (b == ChDquote) begin
          quote_q = QuoteDouble;
          slash_q = 1'b0;
        end else if (b == ChSquote) begin
          quote_q = QuoteSingle;
          slash_q = 1'b0;
        end else if (b == ChGt) begin
          if (scan_q == ScStart) begin
            if (slash_q) t.frag_kind = KindEmpty;
            else if (int'(depth_q) >= DepthCap) err = ErrDepth;
            else depth_q++;
          end else if (scan_q == ScEnd) begin
            if (depth_q == 8'd0) err = ErrDepth;
            else depth_q--;
          end
          if (err == ErrNone) begin
            t.frag_end = 1'b1;
            scan_q = ScIdle;
            quote_q = QuoteNone;
            slash_q = 1'b0;
          end
        end else slash_q = (b == ChSlash);
      end

      if (err != ErrNone) err_q = err;
    end

    if (err_q != ErrNone) begin
      t.frag_kind = KindText;
      t.frag_start = 1'b0;
      t.frag_end = 1'b0;
      t.doctype_flag = 1'b0;
      t.doc_done = 1'b0;
    end
    t.nest_depth = depth_q;
    t.error_code = err_q;
    return t;
  endfunction

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_n++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tok_t want;
    if (!rst_ni) begin
      scan_q = ScIdle;
      match_pos = '0;
      run_q = '0;
      quote_q = QuoteNone;
      slash_q = 1'b0;
      depth_q = '0;
      err_q = ErrNone;
      tok_exp_q.delete();
      fail_n = 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        tok_exp_q = {tok_exp_q, tokenize_byte(byte_mon.data_byte)};
      end
      if (tok_mon.valid && tok_mon.ready) begin
        if (tok_exp_q.size() == 0) begin
          $error("token transfer for byte %02h with no byte pending", tok_mon.byte_echo);
          fail_n++;
        end else begin
          want = tok_exp_q.pop_front();
          check_field("byte_echo", want.byte_echo, tok_mon.byte_echo);
          check_field("frag_kind", want.frag_kind, tok_mon.frag_kind);
          check_field("frag_start", want.frag_start, tok_mon.frag_start);
          check_field("frag_end", want.frag_end, tok_mon.frag_end);
          check_field("doctype_flag", want.doctype_flag, tok_mon.doctype_flag);
          check_field("nest_depth", want.nest_depth, tok_mon.nest_depth);
          check_field("doc_done", want.doc_done, tok_mon.doc_done);
          check_field("error_code", want.error_code, tok_mon.error_code);
        end
      end
    end
  end

endmodule

// ----- verif/xml_fragment_tokenizer_tb.sv -----
`timescale 1ns / 1ps

module xml_fragment_tokenizer_tb;
  import xft_pkg::*;

  localparam int unsigned TbMaxDepth = 255;

  logic clk_i;
  logic rst_ni;

  xft_byte_if byte_if ();
  xft_tok_if  tok_if ();

  int fail_n;
  int pending_n;

  xml_fragment_tokenizer #(
    .MAX_DEPTH(TbMaxDepth)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_if),
    .tok_out_o (tok_if)
  );

  xft_tokenizer_checker #(
    .MAX_DEPTH(TbMaxDepth)
  ) checker_i (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_mon  (byte_if),
    .tok_mon   (tok_if),
    .fail_o    (fail_n),
    .pending_o (pending_n)
  );

  byte_t       doc_q[$];
  int          gen_depth;
  int unsigned sent_n;
  int unsigned tx_left;
  bit          tx_calm;
  int unsigned rx_left;
  bit          rx_calm;
  int unsigned rx_hold;
  int unsigned stall;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $error("timeout with %0d tokens still pending", pending_n);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // token sink: random stall after each transfer, with calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
      rx_hold <= 0;
      rx_left = 0;
      rx_calm = 1'b0;
    end else if (tok_if.ready) begin
      if (tok_if.valid) begin
        if (rx_left == 0) begin
          rx_calm = ($urandom_range(0, 3) == 0);
          rx_left = 40;
        end
        rx_left = rx_left - 1;
        stall = rx_calm ? 0 : $urandom_range(0, 7);
        if (stall != 0) begin
          tok_if.ready <= 1'b0;
          rx_hold <= stall;
        end
      end
    end else if (rx_hold <= 1) begin
      tok_if.ready <= 1'b1;
      rx_hold <= 0;
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  task automatic send_byte(input byte_t b);
    int unsigned gap;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = 40;
    end
    tx_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    sent_n++;
  endtask

  task automatic add_byte(input byte_t c);
    doc_q = {doc_q, c};
  endtask

  task automatic flush_doc();
    while (doc_q.size() > 0) send_byte(doc_q.pop_front());
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic push_text();
    byte_t c;
    repeat ($urandom_range(1, 6)) begin
      do c = byte_t'($urandom_range(1, 255)); while (c == ChLt);
      add_byte(c);
    end
  endtask

  // attribute-like body; quoted values may hold '>', '/' and the other quote
  task automatic push_tag_body(input int unsigned n, inout byte_t last);
    byte_t c;
    byte_t q;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          q = $urandom_range(0, 1) ? ChDquote : ChSquote;
          add_byte(q);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 3) == 0) c = ChGt;
            else do c = byte_t'($urandom_range(1, 255)); while (c == q);
            add_byte(c);
          end
          add_byte(q);
          last = q;
        end
        1: begin
          add_byte(ChSlash);
          last = ChSlash;
        end
        default: begin
          do c = byte_t'($urandom_range(1, 255));
          while (c == ChGt || c == ChDquote || c == ChSquote);
          add_byte(c);
          last = c;
        end
      endcase
    end
  endtask

  task automatic push_start(input bit empty_tag);
    byte_t last;
    last = ($urandom_range(0, 3) == 0) ? byte_t'($urandom_range(128, 255))
                                       : byte_t'(8'h61 + $urandom_range(0, 25));
    add_byte(ChLt);
    add_byte(last);
    push_tag_body($urandom_range(0, 4), last);
    if (empty_tag) add_byte(ChSlash);
    else if (last == ChSlash) add_byte(8'h61);
    add_byte(ChGt);
    if (!empty_tag) gen_depth++;
  endtask

  task automatic push_end();
    byte_t last;
    last = ChSlash;
    push_str("</");
    push_tag_body($urandom_range(0, 3), last);
    add_byte(ChGt);
    if (gen_depth > 0) gen_depth--;
  endtask

  task automatic push_decl();
    byte_t last;
    last = ChQuest;
    push_str("<?xml");
    push_tag_body($urandom_range(0, 4), last);
    push_str("?>");
  endtask

  // comment body never holds '>' after exactly two dashes
  task automatic push_comment();
    byte_t       c;
    int unsigned run;
    run = 0;
    push_str("<!--");
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 5))
        0, 1, 2: c = ChDash;
        3:       c = ChGt;
        default: c = byte_t'($urandom_range(1, 255));
      endcase
      if (c == ChGt && run == 2) c = 8'h78;
      if (c == ChDash) run = (run < 3) ? run + 1 : 3;
      else run = 0;
      add_byte(c);
    end
    if (run != 0) add_byte(8'h78);
    push_str("-->");
  endtask

  task automatic push_cdata();
    byte_t       c;
    int unsigned run;
    run = 0;
    push_str("<![CDATA[");
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 5))
        0, 1, 2: c = ChRBracket;
        3:       c = ChGt;
        default: c = byte_t'($urandom_range(1, 255));
      endcase
      if (c == ChGt && run >= 2) c = 8'h78;
      if (c == ChRBracket) run = (run < 2) ? run + 1 : 2;
      else run = 0;
      add_byte(c);
    end
    if ($urandom_range(0, 2) == 0) add_byte(ChRBracket);
    push_str("]]>");
  endtask

  task automatic push_doctype();
    byte_t c;
    push_str("<!DOCTYPE");
    repeat ($urandom_range(0, 8)) begin
      do c = byte_t'($urandom_range(1, 255)); while (c == ChGt);
      add_byte(c);
    end
    add_byte(ChGt);
  endtask

  initial begin
    string       pre;
    int unsigned end_sel;
    int unsigned loop_target;
    rst_ni <= 1'b0;
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= '0;
    gen_depth = 0;
    sent_n = 0;
    tx_left = 0;
    tx_calm = 1'b0;
    // long endings get a shorter random part so the total stays about the same
    end_sel = $urandom_range(0, 5);
    loop_target = (end_sel == 4) ? 850 : (end_sel == 3) ? 1300 : 1500;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed document: every fragment kind and the awkward closings
    push_str("<?xml version=\"1.0\" s='a>b'?>");
    push_str("\001\377 text");
    push_str("<root a='x>y' b=\"it's/\">");
    push_str("<e/>");
    push_str("<f x=\"q\"/>");
    push_str("<>");
    push_str("</>");
    push_str("<!-->-->");
    push_str("<!-- a --->b-- ->-->");
    push_str("<![CDATA[x]>]]]>");
    push_str("<!DOCTYPE r [\"x\"]>");
    push_str("</root x=\">\">");
    push_str("tail");
    flush_doc();

    // random well-formed fragments
    while (sent_n < loop_target) begin
      case ($urandom_range(0, 13))
        0, 1, 2: push_text();
        3, 4, 5: push_start(gen_depth >= 40);
        6:       push_start(1'b1);
        7, 8, 9: if (gen_depth > 0) push_end(); else push_text();
        10:      push_comment();
        11:      push_cdata();
        12:      push_doctype();
        default: push_decl();
      endcase
      flush_doc();
    end

    // one way of ending the document; every later byte must be held off
    case (end_sel)
      0: begin
        push_text();
        add_byte(ChNul);
      end
      1: begin
        case ($urandom_range(0, 5))
          0:       pre = "<!x";
          1:       pre = "<?xmL";
          2:       pre = "<![CDAT!";
          3:       pre = "<!-x";
          4:       pre = "<!DOCTYP!";
          default: pre = "<?a";
        endcase
        push_str(pre);
      end
      2: begin
        case ($urandom_range(0, 8))
          0:       pre = "<";
          1:       pre = "<a b='";
          2:       pre = "<!--ab-";
          3:       pre = "<![CDATA[x]";
          4:       pre = "<!DOC";
          5:       pre = "<?x";
          6:       pre = "</a";
          7:       pre = "<?xml v=\"";
          default: pre = "<!DOCTYPE r";
        endcase
        push_str(pre);
        add_byte(ChNul);
      end
      3: begin
        // closing more elements than are open
        while (gen_depth > 0) push_end();
        push_end();
      end
      4: begin
        // nesting past the depth limit
        while (gen_depth < 255) begin
          push_str("<a>");
          gen_depth++;
        end
        push_str("<b>");
      end
      default: add_byte(ChNul);
    endcase
    repeat (24) add_byte(byte_t'($urandom_range(0, 255)));
    flush_doc();
    byte_if.valid <= 1'b0;

    while (pending_n != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_n == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/xft_pkg.sv
rtl/xft_if.sv
rtl/xml_fragment_tokenizer.sv
verif/xft_tokenizer_checker.sv
verif/xml_fragment_tokenizer_tb.sv
